@@ rtl/core/btpc_pkg.sv @@
// Shared types and constants for the barometric temperature/pressure compensation block.
// Used by btpc_div and baro_temp_pressure_compensation; no dependencies.
package btpc_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_TEMP_TRIM  = 2'd0,
    REG_PRESS_LOW  = 2'd1,
    REG_PRESS_HIGH = 2'd2,
    REG_PRESS_NINE = 2'd3
  } btpc_reg_t;

  // Divider geometry: 64-bit dividend, divisor magnitude at most 2^30
  localparam int QW         = 64;
  localparam int RW         = 31;
  localparam int DIV_BITS   = 2;
  localparam int DIV_STAGES = QW / DIV_BITS;

  localparam logic signed [25:0] FINE_OFFSET = 26'sd128000;
  localparam logic [20:0]        PRESS_BASE  = 21'd1048576;
  localparam logic [11:0]        NUM_SCALE   = 12'd3125;
  localparam logic [63:0]        Y_BIAS      = 64'h0000_8000_0000_0000;

  // Side information that travels with a transaction through the divider
  typedef struct packed {
    logic        vld;
    logic        neg;
    logic        dz;
    logic [15:0] tc;
  } btpc_ctl_t;

endpackage

@@ rtl/core/btpc_div.sv @@
// Pipelined restoring divider, unsigned 64-bit dividend by 31-bit divisor.
// Two quotient bits per stage; depends on btpc_pkg.
module btpc_div import btpc_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  btpc_ctl_t       in_ctl,
  input  logic [QW-1:0]   in_dividend,
  input  logic [RW-1:0]   in_divisor,
  output btpc_ctl_t       out_ctl,
  output logic [QW-1:0]   out_quotient
);

  btpc_ctl_t       ctl_r   [DIV_STAGES];
  logic [QW-1:0]   dq_r    [DIV_STAGES];
  logic [RW-1:0]   rem_r   [DIV_STAGES];
  logic [RW-1:0]   dvs_r   [DIV_STAGES];
  btpc_ctl_t       ctl_nxt [DIV_STAGES];
  logic [QW-1:0]   dq_nxt  [DIV_STAGES];
  logic [RW-1:0]   rem_nxt [DIV_STAGES];
  logic [RW-1:0]   dvs_nxt [DIV_STAGES];

  always_comb begin
    logic [RW:0]   trial;
    logic [QW-1:0] dq;
    logic [RW-1:0] rem;
    trial = '0;
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (k == 0) begin
        ctl_nxt[k] = in_ctl;
        dq         = in_dividend;
        rem        = '0;
        dvs_nxt[k] = in_divisor;
      end else begin
        ctl_nxt[k] = ctl_r[k-1];
        dq         = dq_r[k-1];
        rem        = rem_r[k-1];
        dvs_nxt[k] = dvs_r[k-1];
      end
      // shift dividend bits out at the top, quotient bits in at the bottom
      for (int i = 0; i < DIV_BITS; i++) begin
        trial = {rem, dq[QW-1]};
        if (trial >= {1'b0, dvs_nxt[k]}) begin
          rem = RW'(trial - {1'b0, dvs_nxt[k]});
          dq  = {dq[QW-2:0], 1'b1};
        end else begin
          rem = trial[RW-1:0];
          dq  = {dq[QW-2:0], 1'b0};
        end
      end
      dq_nxt[k]  = dq;
      rem_nxt[k] = rem;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (!rst_n) begin
        ctl_r[k].vld <= 1'b0;
      end else if (en) begin
        ctl_r[k] <= ctl_nxt[k];
        dq_r[k]  <= dq_nxt[k];
        rem_r[k] <= rem_nxt[k];
        dvs_r[k] <= dvs_nxt[k];
      end
    end
  end

  assign out_ctl      = ctl_r[DIV_STAGES-1];
  assign out_quotient = dq_r[DIV_STAGES-1];

endmodule

@@ rtl/core/baro_temp_pressure_compensation.sv @@
// Top level of the barometric temperature/pressure compensation pipeline.
// Depends on btpc_pkg and btpc_div.
//
// Input channel: in_valid/in_stall with a raw 20-bit pressure and temperature
// reading per transaction. Result channel: out_valid/out_stall with the
// temperature in 0.01 degC (saturated), pressure in Pa as Q24.8 (clamped) and
// a flag that marks a zero pressure divisor (pressure then reads 0).
// Trim coefficients are loaded through cfg_we/cfg_addr/cfg_wdata; write them
// only while no transaction is in flight.
// The pipeline is 12 stages of temperature and pressure arithmetic, a 32-stage
// divider resolving two quotient bits per stage, 5 stages of final pressure
// arithmetic and the output register. Throughput is one transaction per cycle
// unless a held result stalls the pipeline; every stage carries a valid bit.
// A stalled result freezes the whole pipeline in place and raises in_stall;
// nothing is lost or repeated. Bubbles keep moving while out_valid is low.
// Synchronous active-low reset clears all valid bits and the trim registers.
module baro_temp_pressure_compensation import btpc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [19:0]        in_raw_pressure,
  input  logic [19:0]        in_raw_temperature,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_temp_centi,
  output logic [31:0]        out_pressure_q24_8,
  output logic               out_div_zero,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_addr,
  input  logic [63:0]        cfg_wdata
);

  logic        en;
  logic [47:0] temp_trim_r;
  logic [63:0] press_low_r;
  logic [63:0] press_high_r;
  logic [15:0] press_nine_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_trim_r  <= '0;
      press_low_r  <= '0;
      press_high_r <= '0;
      press_nine_r <= '0;
    end else if (cfg_we) begin
      case (btpc_reg_t'(cfg_addr))
        REG_TEMP_TRIM:  temp_trim_r  <= cfg_wdata[47:0];
        REG_PRESS_LOW:  press_low_r  <= cfg_wdata;
        REG_PRESS_HIGH: press_high_r <= cfg_wdata;
        REG_PRESS_NINE: press_nine_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  logic [15:0]        t1, p1;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;
  assign t1 = temp_trim_r[15:0];
  assign t2 = $signed(temp_trim_r[31:16]);
  assign t3 = $signed(temp_trim_r[47:32]);
  assign p1 = press_low_r[15:0];
  assign p2 = $signed(press_low_r[31:16]);
  assign p3 = $signed(press_low_r[47:32]);
  assign p4 = $signed(press_low_r[63:48]);
  assign p5 = $signed(press_high_r[15:0]);
  assign p6 = $signed(press_high_r[31:16]);
  assign p7 = $signed(press_high_r[47:32]);
  assign p8 = $signed(press_high_r[63:48]);
  assign p9 = $signed(press_nine_r);

  // advance unless a finished result is held
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  logic [11:0] pre_vld_r;
  logic [4:0]  post_vld_r;
  btpc_ctl_t   div_ctl, div_in_ctl;
  logic [QW-1:0] div_q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_vld_r  <= '0;
      post_vld_r <= '0;
      out_valid  <= 1'b0;
    end else if (en) begin
      pre_vld_r  <= {pre_vld_r[10:0], in_valid};
      post_vld_r <= {post_vld_r[3:0], div_ctl.vld};
      out_valid  <= post_vld_r[4];
    end
  end

  // ---------------- temperature and divisor/dividend stages ----------------
  logic signed [17:0] s1_a_r, s1_a_nxt;
  logic signed [16:0] s1_b_r, s1_b_nxt;
  logic [19:0]        s1_adc_r;
  assign s1_a_nxt = $signed({1'b0, in_raw_temperature[19:3]}) - $signed({1'b0, t1, 1'b0});
  assign s1_b_nxt = $signed({1'b0, in_raw_temperature[19:4]}) - $signed({1'b0, t1});

  logic signed [33:0] s2_m1_r, s2_m1_nxt, s2_bb_r, s2_bb_nxt;
  logic [19:0]        s2_adc_r;
  assign s2_m1_nxt = s1_a_r * t2;
  assign s2_bb_nxt = s1_b_r * s1_b_r;

  logic signed [22:0] s3_v1_r, s3_v1_nxt;
  logic signed [21:0] s3_bbs;
  logic signed [37:0] s3_m2_r, s3_m2_nxt;
  logic [19:0]        s3_adc_r;
  assign s3_v1_nxt = $signed(s2_m1_r[33:11]);
  assign s3_bbs    = $signed(s2_bb_r[33:12]);
  assign s3_m2_nxt = s3_bbs * t3;

  logic signed [24:0] s4_fine_r, s4_fine_nxt;
  logic [19:0]        s4_adc_r;
  assign s4_fine_nxt = {{2{s3_v1_r[22]}}, s3_v1_r} + {s3_m2_r[37], s3_m2_r[37:14]};

  logic signed [25:0] s5_pv_r, s5_pv_nxt;
  logic signed [27:0] s5_fe, s5_t5;
  logic signed [19:0] s5_tsh;
  logic [15:0]        s5_tc_r, s5_tc_nxt;
  logic [19:0]        s5_adc_r;
  assign s5_pv_nxt = 26'(s4_fine_r) - FINE_OFFSET;
  assign s5_fe     = 28'(s4_fine_r);
  assign s5_t5     = s5_fe + (s5_fe <<< 2) + 28'sd128;
  assign s5_tsh    = $signed(s5_t5[27:8]);
  always_comb begin
    if (s5_tsh > 20'sd32767) begin
      s5_tc_nxt = 16'h7fff;
    end else if (s5_tsh < -20'sd32768) begin
      s5_tc_nxt = 16'h8000;
    end else begin
      s5_tc_nxt = s5_tsh[15:0];
    end
  end

  logic signed [51:0] s6_sq_r, s6_sq_nxt;
  logic signed [41:0] s6_mp5_r, s6_mp5_nxt, s6_mp2_r, s6_mp2_nxt;
  logic [15:0]        s6_tc_r;
  logic [19:0]        s6_adc_r;
  assign s6_sq_nxt  = s5_pv_r * s5_pv_r;
  assign s6_mp5_nxt = s5_pv_r * p5;
  assign s6_mp2_nxt = s5_pv_r * p2;

  logic signed [63:0] s7_x6_r, s7_x6_nxt, s7_x3_r, s7_x3_nxt, s7_v2a_r, s7_v2a_nxt;
  logic signed [41:0] s7_mp2_r;
  logic [15:0]        s7_tc_r;
  logic [19:0]        s7_adc_r;
  assign s7_x6_nxt  = s6_sq_r * p6;
  assign s7_x3_nxt  = s6_sq_r * p3;
  assign s7_v2a_nxt = (64'(s6_mp5_r) <<< 17) + (64'(p4) <<< 35);

  logic signed [63:0] s8_x3s, s8_mp2s;
  logic [63:0]        s8_v2_r, s8_v2_nxt, s8_y_r, s8_y_nxt;
  logic [15:0]        s8_tc_r;
  logic [19:0]        s8_adc_r;
  assign s8_x3s    = s7_x3_r >>> 8;
  assign s8_mp2s   = 64'(s7_mp2_r) <<< 12;
  assign s8_v2_nxt = s7_x6_r + s7_v2a_r;
  assign s8_y_nxt  = s8_x3s + s8_mp2s + Y_BIAS;

  logic [47:0] s9_plo_r, s9_plo_nxt, s9_phi_r, s9_phi_nxt;
  logic [20:0] s9_pdiff;
  logic [63:0] s9_pd_r, s9_pd_nxt;
  logic [15:0] s9_tc_r;
  assign s9_plo_nxt = s8_y_r[31:0] * p1;
  assign s9_phi_nxt = s8_y_r[63:32] * p1;
  assign s9_pdiff   = PRESS_BASE - {1'b0, s8_adc_r};
  assign s9_pd_nxt  = {12'd0, s9_pdiff, 31'd0} - s8_v2_r;

  logic [63:0] s10_yp;
  logic [30:0] s10_dvs_r, s10_dvs_nxt;
  logic [43:0] s10_nlo_r, s10_nlo_nxt, s10_nhi_r, s10_nhi_nxt;
  logic [15:0] s10_tc_r;
  assign s10_yp      = 64'(s9_plo_r) + {s9_phi_r[31:0], 32'd0};
  assign s10_dvs_nxt = s10_yp[63:33];
  assign s10_nlo_nxt = s9_pd_r[31:0] * NUM_SCALE;
  assign s10_nhi_nxt = s9_pd_r[63:32] * NUM_SCALE;

  logic [63:0] s11_num_r, s11_num_nxt;
  logic [30:0] s11_dvs_r;
  logic [15:0] s11_tc_r;
  assign s11_num_nxt = 64'(s10_nlo_r) + {s10_nhi_r[31:0], 32'd0};

  // divide magnitudes, restore the sign afterwards
  logic [63:0] s12_nabs_r, s12_nabs_nxt;
  logic [RW-1:0] s12_dabs_r, s12_dabs_nxt;
  logic        s12_neg_r, s12_dz_r;
  logic [15:0] s12_tc_r;
  assign s12_nabs_nxt = s11_num_r[63] ? -s11_num_r : s11_num_r;
  assign s12_dabs_nxt = s11_dvs_r[30] ? RW'(-s11_dvs_r) : s11_dvs_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_a_r     <= s1_a_nxt;
      s1_b_r     <= s1_b_nxt;
      s1_adc_r   <= in_raw_pressure;
      s2_m1_r    <= s2_m1_nxt;
      s2_bb_r    <= s2_bb_nxt;
      s2_adc_r   <= s1_adc_r;
      s3_v1_r    <= s3_v1_nxt;
      s3_m2_r    <= s3_m2_nxt;
      s3_adc_r   <= s2_adc_r;
      s4_fine_r  <= s4_fine_nxt;
      s4_adc_r   <= s3_adc_r;
      s5_pv_r    <= s5_pv_nxt;
      s5_tc_r    <= s5_tc_nxt;
      s5_adc_r   <= s4_adc_r;
      s6_sq_r    <= s6_sq_nxt;
      s6_mp5_r   <= s6_mp5_nxt;
      s6_mp2_r   <= s6_mp2_nxt;
      s6_tc_r    <= s5_tc_r;
      s6_adc_r   <= s5_adc_r;
      s7_x6_r    <= s7_x6_nxt;
      s7_x3_r    <= s7_x3_nxt;
      s7_v2a_r   <= s7_v2a_nxt;
      s7_mp2_r   <= s6_mp2_r;
      s7_tc_r    <= s6_tc_r;
      s7_adc_r   <= s6_adc_r;
      s8_v2_r    <= s8_v2_nxt;
      s8_y_r     <= s8_y_nxt;
      s8_tc_r    <= s7_tc_r;
      s8_adc_r   <= s7_adc_r;
      s9_plo_r   <= s9_plo_nxt;
      s9_phi_r   <= s9_phi_nxt;
      s9_pd_r    <= s9_pd_nxt;
      s9_tc_r    <= s8_tc_r;
      s10_dvs_r  <= s10_dvs_nxt;
      s10_nlo_r  <= s10_nlo_nxt;
      s10_nhi_r  <= s10_nhi_nxt;
      s10_tc_r   <= s9_tc_r;
      s11_num_r  <= s11_num_nxt;
      s11_dvs_r  <= s10_dvs_r;
      s11_tc_r   <= s10_tc_r;
      s12_nabs_r <= s12_nabs_nxt;
      s12_dabs_r <= s12_dabs_nxt;
      s12_neg_r  <= s11_num_r[63] ^ s11_dvs_r[30];
      s12_dz_r   <= (s11_dvs_r == '0);
      s12_tc_r   <= s11_tc_r;
    end
  end

  assign div_in_ctl = '{vld: pre_vld_r[11], neg: s12_neg_r, dz: s12_dz_r, tc: s12_tc_r};

  btpc_div u_div (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .in_ctl       (div_in_ctl),
    .in_dividend  (s12_nabs_r),
    .in_divisor   (s12_dabs_r),
    .out_ctl      (div_ctl),
    .out_quotient (div_q)
  );

  // ---------------- final pressure stages ----------------
  logic signed [63:0] q1_r, q1_nxt;
  logic               q1_dz_r;
  logic [15:0]        q1_tc_r;
  assign q1_nxt = div_ctl.neg ? -div_q : div_q;

  logic signed [50:0] q2_qs;
  logic signed [63:0] q2_q_r, q2_m_r, q2_m_nxt;
  logic signed [48:0] q2_ml_r, q2_ml_nxt;
  logic signed [47:0] q2_mh_r, q2_mh_nxt;
  logic               q2_dz_r;
  logic [15:0]        q2_tc_r;
  assign q2_qs     = $signed(q1_r[63:13]);
  assign q2_m_nxt  = q2_qs * p9;
  assign q2_ml_nxt = $signed({1'b0, q1_r[31:0]}) * p8;
  assign q2_mh_nxt = $signed(q1_r[63:32]) * p8;

  // 64x64 product modulo 2^64 from 32-bit partial products
  logic [63:0]        q3_qse, q3_pp0_r, q3_pp0_nxt;
  logic [31:0]        q3_pp1_r, q3_pp1_nxt, q3_pp2_r, q3_pp2_nxt;
  logic signed [63:0] q3_v2w, q3_v2_r, q3_v2_nxt, q3_q_r;
  logic               q3_dz_r;
  logic [15:0]        q3_tc_r;
  assign q3_qse     = 64'($signed(q2_q_r[63:13]));
  assign q3_pp0_nxt = q2_m_r[31:0] * q3_qse[31:0];
  assign q3_pp1_nxt = q2_m_r[31:0] * q3_qse[63:32];
  assign q3_pp2_nxt = q2_m_r[63:32] * q3_qse[31:0];
  assign q3_v2w     = 64'(q2_ml_r) + (64'(q2_mh_r) <<< 32);
  assign q3_v2_nxt  = q3_v2w >>> 19;

  logic signed [63:0] q4_prod, q4_v1_r, q4_v1_nxt, q4_s_r, q4_s_nxt;
  logic               q4_dz_r;
  logic [15:0]        q4_tc_r;
  assign q4_prod   = q3_pp0_r + {q3_pp1_r + q3_pp2_r, 32'd0};
  assign q4_v1_nxt = q4_prod >>> 25;
  assign q4_s_nxt  = q3_q_r + q3_v2_r;

  logic signed [63:0] q5_sum, q5_r_r, q5_r_nxt;
  logic               q5_dz_r;
  logic [15:0]        q5_tc_r;
  assign q5_sum   = (q4_s_r + q4_v1_r) >>> 8;
  assign q5_r_nxt = q5_sum + (64'(p7) <<< 4);

  logic [31:0] out_press_nxt;
  always_comb begin
    if (q5_dz_r || q5_r_r[63]) begin
      out_press_nxt = '0;
    end else if (q5_r_r[62:32] != '0) begin
      out_press_nxt = '1;
    end else begin
      out_press_nxt = q5_r_r[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q1_r               <= q1_nxt;
      q1_dz_r            <= div_ctl.dz;
      q1_tc_r            <= div_ctl.tc;
      q2_q_r             <= q1_r;
      q2_m_r             <= q2_m_nxt;
      q2_ml_r            <= q2_ml_nxt;
      q2_mh_r            <= q2_mh_nxt;
      q2_dz_r            <= q1_dz_r;
      q2_tc_r            <= q1_tc_r;
      q3_pp0_r           <= q3_pp0_nxt;
      q3_pp1_r           <= q3_pp1_nxt;
      q3_pp2_r           <= q3_pp2_nxt;
      q3_v2_r            <= q3_v2_nxt;
      q3_q_r             <= q2_q_r;
      q3_dz_r            <= q2_dz_r;
      q3_tc_r            <= q2_tc_r;
      q4_v1_r            <= q4_v1_nxt;
      q4_s_r             <= q4_s_nxt;
      q4_dz_r            <= q3_dz_r;
      q4_tc_r            <= q3_tc_r;
      q5_r_r             <= q5_r_nxt;
      q5_dz_r            <= q4_dz_r;
      q5_tc_r            <= q4_tc_r;
      out_pressure_q24_8 <= out_press_nxt;
      out_div_zero       <= q5_dz_r;
      out_temp_centi     <= $signed(q5_tc_r);
    end
  end

`ifndef SYNTHESIS
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_div_zero |-> out_pressure_q24_8 == '0)
    else $error("pressure not zero with zero divisor");

  a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while pipeline held");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");
`endif

endmodule
